// ----- src/reflective_meter_pulse_counter_core_defines.svh -----
// Assertion macros for the checker file of the pulse counter core.
`ifndef REFLECTIVE_METER_PULSE_COUNTER_CORE_DEFINES_SVH
`define REFLECTIVE_METER_PULSE_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RMPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RMPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rmpc_pkg.sv -----
// Shared types, constants and codes of the reflective meter pulse counter.
package rmpc_pkg;

    localparam int ADC_BITS_DEF   = 10;
    localparam int CAL_PULSES_DEF = 20;

    localparam int NM_W         = 10;
    localparam int STILL_W      = 16;
    localparam int FAST_W       = 14;
    localparam int DIVISOR_W    = 8;
    localparam int COUNT_W      = 32;
    localparam int TIME_W       = 32;
    localparam int DIVIDEND_W   = 32;
    localparam int DELAY_W      = 16;
    localparam int WORK_W       = 32;
    localparam int SAMPLE_CNT_W = 16;
    localparam int FAST_PULSE_W = 8;
    localparam int EDGE_W       = 2;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MARGIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_DELAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT    = 3'd4;

    // Configuration reset values.
    localparam logic [NM_W-1:0]      NM_RST         = 10'd18;
    localparam logic [STILL_W-1:0]   STILL_RST      = 16'd200;
    localparam logic [FAST_W-1:0]    FAST_RST       = 14'd5;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RST    = 8'd4;
    localparam logic [COUNT_W-1:0]   INIT_COUNT_RST = 32'd0;

    // Mode machine limits.
    localparam logic [SAMPLE_CNT_W-1:0] FAST_SAMPLE_LIMIT      = 16'd14;
    localparam logic [FAST_PULSE_W-1:0] FAST_PULSE_LIMIT       = 8'd4;
    localparam logic [WORK_W-1:0]       STILL_TIMEOUT_MS       = 32'd2000;
    localparam logic [SAMPLE_CNT_W-1:0] ADJUST_SAMPLES         = 16'd6;
    localparam logic [SAMPLE_CNT_W-1:0] SHORT_INTERVAL_SAMPLES = 16'd2;
    localparam int                      NORMAL_DELAY_SHIFT     = 2;

    // Edge codes.
    localparam logic [EDGE_W-1:0] EDGE_NONE = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_RISE = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_FULL = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_STILL  = 2'd0,
        MODE_FAST   = 2'd1,
        MODE_NORMAL = 2'd2
    } t_mode;

    typedef struct packed {
        logic [NM_W-1:0]      noise_margin;
        logic [STILL_W-1:0]   still_delay_ms;
        logic [FAST_W-1:0]    fast_delay_ms;
        logic [DIVISOR_W-1:0] delay_divisor;
        logic [COUNT_W-1:0]   initial_pulse_count;
    } t_cfg;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- src/rmpc_if.sv -----
// Valid/ready channel interfaces for samples, results and configuration writes.
interface rmpc_in_if #(
    parameter int ADC_BITS = rmpc_pkg::ADC_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [ADC_BITS-1:0]         dark_sample;
    logic [ADC_BITS-1:0]         bright_sample;
    logic [rmpc_pkg::TIME_W-1:0] time_ms;

    modport source (output valid, dark_sample, bright_sample, time_ms, input ready);
    modport sink   (input valid, dark_sample, bright_sample, time_ms, output ready);
endinterface

interface rmpc_out_if #(
    parameter int ADC_BITS = rmpc_pkg::ADC_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [rmpc_pkg::DELAY_W-1:0] next_delay_ms;
    logic [rmpc_pkg::COUNT_W-1:0] pulse_count;
    logic [rmpc_pkg::EDGE_W-1:0]  edge_seen;
    logic [rmpc_pkg::MODE_W-1:0]  meter_mode;
    logic                         calibrated;
    logic                         out_of_window;
    logic [ADC_BITS-1:0]          reflectance;

    modport source (output valid, next_delay_ms, pulse_count, edge_seen, meter_mode,
                    calibrated, out_of_window, reflectance, input ready);
    modport sink   (input valid, next_delay_ms, pulse_count, edge_seen, meter_mode,
                    calibrated, out_of_window, reflectance, output ready);
endinterface

interface rmpc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rmpc_pkg::CFG_IDX_W-1:0]  index;
    logic [rmpc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/rmpc_cfg_regs.sv -----
// Configuration register file of the pulse counter core.
module rmpc_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rmpc_cfg_if.sink       i_cfg,
    output rmpc_pkg::t_cfg o_cfg
);

    rmpc_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_margin        <= rmpc_pkg::NM_RST;
            r_cfg.still_delay_ms      <= rmpc_pkg::STILL_RST;
            r_cfg.fast_delay_ms       <= rmpc_pkg::FAST_RST;
            r_cfg.delay_divisor       <= rmpc_pkg::DIVISOR_RST;
            r_cfg.initial_pulse_count <= rmpc_pkg::INIT_COUNT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rmpc_pkg::CFG_NOISE_MARGIN: begin
                    r_cfg.noise_margin <= i_cfg.data[rmpc_pkg::NM_W-1:0];
                end
                rmpc_pkg::CFG_STILL_DELAY: begin
                    r_cfg.still_delay_ms <= i_cfg.data[rmpc_pkg::STILL_W-1:0];
                end
                rmpc_pkg::CFG_FAST_DELAY: begin
                    r_cfg.fast_delay_ms <= i_cfg.data[rmpc_pkg::FAST_W-1:0];
                end
                rmpc_pkg::CFG_DELAY_DIVISOR: begin
                    r_cfg.delay_divisor <= i_cfg.data[rmpc_pkg::DIVISOR_W-1:0];
                end
                rmpc_pkg::CFG_INIT_COUNT: begin
                    r_cfg.initial_pulse_count <= i_cfg.data[rmpc_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- src/rmpc_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module rmpc_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rmpc_pkg::t_div_req i_req,
    output rmpc_pkg::t_div_rsp o_rsp
);

    localparam int DW     = rmpc_pkg::DIVIDEND_W;
    localparam int VW     = rmpc_pkg::DIVISOR_W;
    localparam int STEP_W = $clog2(DW);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DW - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DW-1:0]     r_quo;
    logic [VW-1:0]     r_rem;
    logic [VW-1:0]     r_divisor;

    logic [VW:0]   shifted;
    logic [VW:0]   trial;
    logic          fits;
    logic [VW-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        trial   = shifted - {1'b0, r_divisor};
        fits    = (shifted >= {1'b0, r_divisor});
        n_rem   = fits ? trial[VW-1:0] : shifted[VW-1:0];
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_step    <= '0;
                r_quo     <= i_req.dividend;
                r_rem     <= '0;
                r_divisor <= i_req.divisor;
            end else if (r_busy) begin
                r_quo  <= {r_quo[DW-2:0], fits};
                r_rem  <= n_rem;
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- src/reflective_meter_pulse_counter_core.sv -----
// Each sample is processed in order: accept, 32 divider steps on the pulse interval, the divide
//   state seeing the divider finish, then four update steps (mode, level, normal, finish;
//   only mode and finish when seeding). Finish waits while the output register is full.
// The sample channel stays not ready until the result is loaded into the output register.
// Reset (i_rst_n low, synchronous) restores register defaults; the next sample only seeds.
module reflective_meter_pulse_counter_core #(
    parameter int ADC_BITS   = rmpc_pkg::ADC_BITS_DEF,
    parameter int CAL_PULSES = rmpc_pkg::CAL_PULSES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmpc_in_if.sink   i_in,
    rmpc_out_if.source o_out,
    rmpc_cfg_if.sink  i_cfg
);

    // Reflectance width, and the compare width that also holds the widened window.
    localparam int AW = ADC_BITS;
    localparam int CW = ((ADC_BITS > rmpc_pkg::NM_W) ? ADC_BITS : rmpc_pkg::NM_W) + 2;
    localparam int WW = rmpc_pkg::WORK_W;
    localparam logic [rmpc_pkg::COUNT_W-1:0] CAL_COUNT = rmpc_pkg::COUNT_W'(CAL_PULSES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_MODE,
        S_LEVEL,
        S_NORMAL,
        S_FINISH
    } t_state;

    rmpc_pkg::t_cfg     cfg;
    rmpc_pkg::t_div_req div_req;
    rmpc_pkg::t_div_rsp div_rsp;

    // Sequencer and persistent detector state.
    t_state                             r_state, n_state;
    logic                               r_seeded, n_seeded;
    rmpc_pkg::t_mode                    r_mode, n_mode;
    logic                               r_level_high, n_level_high;
    logic [AW-1:0]                      r_mode_ref, n_mode_ref;
    logic [AW-1:0]                      r_run_min, n_run_min;
    logic [AW-1:0]                      r_run_max, n_run_max;
    logic [CW-1:0]                      r_win_low, n_win_low;
    logic [CW-1:0]                      r_win_high, n_win_high;
    logic [rmpc_pkg::SAMPLE_CNT_W-1:0]  r_ssp, n_ssp;
    logic [rmpc_pkg::SAMPLE_CNT_W-1:0]  r_ssa, n_ssa;
    logic [rmpc_pkg::FAST_PULSE_W-1:0]  r_fast_pulses, n_fast_pulses;
    logic [rmpc_pkg::TIME_W-1:0]        r_last_time, n_last_time;
    logic [rmpc_pkg::DELAY_W-1:0]       r_delay, n_delay;
    logic [rmpc_pkg::COUNT_W-1:0]       r_count, n_count;

    // Per-sample working registers.
    logic [AW-1:0]                r_refl, n_refl;
    logic [rmpc_pkg::TIME_W-1:0]  r_now, n_now;
    logic [rmpc_pkg::TIME_W-1:0]  r_dt, n_dt;
    logic [WW-1:0]                r_work, n_work;
    logic [rmpc_pkg::EDGE_W-1:0]  r_edge, n_edge;
    logic                         r_oow, n_oow;

    // Output register.
    logic                         r_out_valid, n_out_valid;
    logic [rmpc_pkg::DELAY_W-1:0] r_o_delay, n_o_delay;
    logic [rmpc_pkg::COUNT_W-1:0] r_o_count, n_o_count;
    logic [rmpc_pkg::EDGE_W-1:0]  r_o_edge, n_o_edge;
    rmpc_pkg::t_mode              r_o_mode, n_o_mode;
    logic                         r_o_cal, n_o_cal;
    logic                         r_o_oow, n_o_oow;
    logic [AW-1:0]                r_o_refl, n_o_refl;

    logic                         in_accept;
    logic [AW-1:0]                refl_in;
    logic [rmpc_pkg::TIME_W-1:0]  dt_in;
    logic [CW-1:0]                refl_c;
    logic [CW-1:0]                nm_c;
    logic [WW-1:0]                still_w;
    logic [WW-1:0]                elapsed;
    logic [WW-1:0]                addend;
    logic [WW:0]                  delay_sum;
    logic                         prev_short;
    logic [rmpc_pkg::DELAY_W-1:0] delay_clamped;

    rmpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    rmpc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Take a sample only between items; the output register decouples the result side.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;

    // Reflectance is lit minus dark, floored at zero.
    assign refl_in = (i_in.bright_sample > i_in.dark_sample) ?
                     (i_in.bright_sample - i_in.dark_sample) : '0;
    // Interval since the last pulse, measured against the stored pulse time.
    assign dt_in   = i_in.time_ms - r_last_time;

    // Launch the interval division on every accepted sample; a zero divisor acts as one.
    assign div_req.start    = in_accept;
    assign div_req.dividend = dt_in;
    assign div_req.divisor  = (cfg.delay_divisor == '0) ? rmpc_pkg::DIVISOR_W'(1)
                                                        : cfg.delay_divisor;

    assign refl_c  = CW'(r_refl);
    assign nm_c    = CW'(cfg.noise_margin);
    assign still_w = WW'(cfg.still_delay_ms);

    // After an edge the pulse time is now, so the elapsed time is zero.
    assign elapsed    = (r_edge != rmpc_pkg::EDGE_NONE) ? '0 : r_dt;
    // One adder serves both averaging steps: with the divided interval on an edge,
    // and with the elapsed time on the periodic adjust in normal mode.
    assign addend     = (r_state == S_LEVEL) ? div_rsp.quotient : elapsed;
    assign delay_sum  = {1'b0, r_work} + {1'b0, addend};
    assign prev_short = (r_ssp < rmpc_pkg::SHORT_INTERVAL_SAMPLES);

    // Clamp the working delay to the still delay.
    assign delay_clamped = (r_work > still_w) ? cfg.still_delay_ms
                                              : r_work[rmpc_pkg::DELAY_W-1:0];

    always_comb begin
        n_state       = r_state;
        n_seeded      = r_seeded;
        n_mode        = r_mode;
        n_level_high  = r_level_high;
        n_mode_ref    = r_mode_ref;
        n_run_min     = r_run_min;
        n_run_max     = r_run_max;
        n_win_low     = r_win_low;
        n_win_high    = r_win_high;
        n_ssp         = r_ssp;
        n_ssa         = r_ssa;
        n_fast_pulses = r_fast_pulses;
        n_last_time   = r_last_time;
        n_delay       = r_delay;
        n_count       = r_count;
        n_refl        = r_refl;
        n_now         = r_now;
        n_dt          = r_dt;
        n_work        = r_work;
        n_edge        = r_edge;
        n_oow         = r_oow;
        // Drop the result once the sink takes it.
        n_out_valid   = r_out_valid && !o_out.ready;
        n_o_delay     = r_o_delay;
        n_o_count     = r_o_count;
        n_o_edge      = r_o_edge;
        n_o_mode      = r_o_mode;
        n_o_cal       = r_o_cal;
        n_o_oow       = r_o_oow;
        n_o_refl      = r_o_refl;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_refl  = refl_in;
                    n_now   = i_in.time_ms;
                    n_dt    = dt_in;
                    n_work  = WW'(r_delay);
                    n_state = S_DIVIDE;
                end
            end

            S_DIVIDE: begin
                if (div_rsp.done) begin
                    n_state = S_MODE;
                end
            end

            S_MODE: begin
                n_edge = rmpc_pkg::EDGE_NONE;
                n_oow  = 1'b0;
                if (!r_seeded) begin
                    // First sample after reset: seed all trackers and skip detection.
                    n_seeded      = 1'b1;
                    n_level_high  = 1'b1;
                    n_mode        = rmpc_pkg::MODE_STILL;
                    n_mode_ref    = r_refl;
                    n_run_min     = r_refl;
                    n_run_max     = r_refl;
                    n_win_low     = refl_c;
                    n_win_high    = refl_c;
                    n_ssp         = '0;
                    n_ssa         = '0;
                    n_fast_pulses = '0;
                    n_last_time   = r_now;
                    n_work        = still_w;
                    n_count       = cfg.initial_pulse_count;
                    n_state       = S_FINISH;
                end else begin
                    // Motion away from the reference wakes the meter into fast mode.
                    if (r_mode == rmpc_pkg::MODE_STILL &&
                        (refl_c > CW'(r_mode_ref) + nm_c ||
                         refl_c + nm_c < CW'(r_mode_ref))) begin
                        n_mode        = rmpc_pkg::MODE_FAST;
                        n_mode_ref    = r_refl;
                        n_fast_pulses = '0;
                        n_work        = WW'(cfg.fast_delay_ms);
                        n_ssp         = '0;
                    end
                    // Leave fast mode after enough samples or pulses.
                    if (n_mode == rmpc_pkg::MODE_FAST &&
                        (n_ssp >= rmpc_pkg::FAST_SAMPLE_LIMIT ||
                         n_fast_pulses > rmpc_pkg::FAST_PULSE_LIMIT)) begin
                        n_mode     = rmpc_pkg::MODE_NORMAL;
                        n_mode_ref = r_refl;
                        n_work     = WW'(cfg.fast_delay_ms) << rmpc_pkg::NORMAL_DELAY_SHIFT;
                        n_ssa      = '0;
                    end
                    n_state = S_LEVEL;
                end
            end

            S_LEVEL: begin
                // Hysteresis detector: track the minimum while high, the maximum while low.
                if (r_level_high) begin
                    if (r_run_min > r_refl) begin
                        n_run_min = r_refl;
                    end
                    if (refl_c > CW'(n_run_min) + nm_c) begin
                        n_run_max    = r_refl;
                        n_level_high = 1'b0;
                        n_edge       = rmpc_pkg::EDGE_RISE;
                    end
                end else begin
                    if (r_run_max < r_refl) begin
                        n_run_max = r_refl;
                    end
                    if (refl_c + nm_c < CW'(n_run_max)) begin
                        n_run_min    = r_refl;
                        n_level_high = 1'b1;
                        n_edge       = rmpc_pkg::EDGE_FULL;
                        n_count      = r_count + 1'b1;
                    end
                end
                // Edge bookkeeping: restart the pulse timer, count fast pulses in fast mode, else adapt the delay.
                if (n_edge != rmpc_pkg::EDGE_NONE) begin
                    n_ssp       = '0;
                    n_last_time = r_now;
                    if (r_mode == rmpc_pkg::MODE_STILL) begin
                        n_mode        = rmpc_pkg::MODE_FAST;
                        n_fast_pulses = '0;
                        n_mode_ref    = r_refl;
                    end
                    if (n_mode == rmpc_pkg::MODE_FAST) begin
                        if (n_fast_pulses != '1) begin
                            n_fast_pulses = n_fast_pulses + 1'b1;
                        end
                    end else begin
                        // Average with the divided interval; halve again on a short pulse.
                        n_work = prev_short ? {1'b0, delay_sum[WW:2]} : delay_sum[WW:1];
                        n_ssa  = '0;
                    end
                end
                n_state = S_NORMAL;
            end

            S_NORMAL: begin
                if (r_mode == rmpc_pkg::MODE_NORMAL) begin
                    if (elapsed > rmpc_pkg::STILL_TIMEOUT_MS) begin
                        // No pulse for too long: fall back to still mode.
                        n_mode     = rmpc_pkg::MODE_STILL;
                        n_mode_ref = r_refl;
                        n_work     = still_w;
                        n_ssa      = '0;
                    end else if (r_ssa > rmpc_pkg::ADJUST_SAMPLES) begin
                        // Periodic adjust toward the time since the last pulse.
                        n_ssa  = '0;
                        n_work = delay_sum[WW:1];
                    end
                end
                // Widen the window during calibration, fix it once, then check against it.
                if (r_count < CAL_COUNT) begin
                    if (refl_c > r_win_high) begin
                        n_win_high = refl_c;
                    end else if (refl_c < r_win_low) begin
                        n_win_low = refl_c;
                    end
                end else if (r_count == CAL_COUNT) begin
                    n_win_low  = (r_win_low > nm_c) ? (r_win_low - nm_c) : '0;
                    n_win_high = r_win_high + nm_c;
                    n_count    = r_count + 1'b1;
                end else begin
                    n_oow = (refl_c > r_win_high) || (refl_c < r_win_low);
                end
                // Saturating sample counters.
                if (r_ssp != '1) begin
                    n_ssp = r_ssp + 1'b1;
                end
                if (n_ssa != '1) begin
                    n_ssa = n_ssa + 1'b1;
                end
                n_state = S_FINISH;
            end

            S_FINISH: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || o_out.ready) begin
                    n_delay     = delay_clamped;
                    n_out_valid = 1'b1;
                    n_o_delay   = delay_clamped;
                    n_o_count   = r_count;
                    n_o_edge    = r_edge;
                    n_o_mode    = r_mode;
                    n_o_cal     = (r_count > CAL_COUNT);
                    n_o_oow     = r_oow;
                    n_o_refl    = r_refl;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_seeded      <= 1'b0;
            r_mode        <= rmpc_pkg::MODE_STILL;
            r_level_high  <= 1'b1;
            r_mode_ref    <= '0;
            r_run_min     <= '0;
            r_run_max     <= '0;
            r_win_low     <= '0;
            r_win_high    <= '0;
            r_ssp         <= '0;
            r_ssa         <= '0;
            r_fast_pulses <= '0;
            r_last_time   <= '0;
            r_delay       <= rmpc_pkg::STILL_RST;
            r_count       <= rmpc_pkg::INIT_COUNT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_seeded      <= n_seeded;
            r_mode        <= n_mode;
            r_level_high  <= n_level_high;
            r_mode_ref    <= n_mode_ref;
            r_run_min     <= n_run_min;
            r_run_max     <= n_run_max;
            r_win_low     <= n_win_low;
            r_win_high    <= n_win_high;
            r_ssp         <= n_ssp;
            r_ssa         <= n_ssa;
            r_fast_pulses <= n_fast_pulses;
            r_last_time   <= n_last_time;
            r_delay       <= n_delay;
            r_count       <= n_count;
            r_out_valid   <= n_out_valid;
            r_refl        <= n_refl;
            r_now         <= n_now;
            r_dt          <= n_dt;
            r_work        <= n_work;
            r_edge        <= n_edge;
            r_oow         <= n_oow;
            r_o_delay     <= n_o_delay;
            r_o_count     <= n_o_count;
            r_o_edge      <= n_o_edge;
            r_o_mode      <= n_o_mode;
            r_o_cal       <= n_o_cal;
            r_o_oow       <= n_o_oow;
            r_o_refl      <= n_o_refl;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.next_delay_ms = r_o_delay;
    assign o_out.pulse_count   = r_o_count;
    assign o_out.edge_seen     = r_o_edge;
    assign o_out.meter_mode    = r_o_mode;
    assign o_out.calibrated    = r_o_cal;
    assign o_out.out_of_window = r_o_oow;
    assign o_out.reflectance   = r_o_refl;

endmodule

// ----- src/rmpc_checker.sv -----
// Port-level checker of the pulse counter core, bound to the top level.
`include "reflective_meter_pulse_counter_core_defines.svh"

module rmpc_checker #(
    parameter int CAL_PULSES = rmpc_pkg::CAL_PULSES_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [rmpc_pkg::COUNT_W-1:0] i_pulse_count,
    input logic [rmpc_pkg::EDGE_W-1:0]  i_edge_seen,
    input logic [rmpc_pkg::MODE_W-1:0]  i_meter_mode,
    input logic                         i_calibrated,
    input logic                         i_out_of_window
);

    localparam logic [rmpc_pkg::COUNT_W-1:0] CAL_COUNT = rmpc_pkg::COUNT_W'(CAL_PULSES);

    // One sample at a time: ready drops right after a transaction.
    `RMPC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "ready after accept")
    // A stalled result stays offered.
    `RMPC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    // Calibrated flag follows the pulse count.
    `RMPC_ASSERT_SAME(a_cal_flag, i_out_valid, i_calibrated == (i_pulse_count > CAL_COUNT), "calibrated mismatch")
    // Window check only runs after calibration.
    `RMPC_ASSERT_SAME(a_oow_cal, i_out_valid && i_out_of_window, i_calibrated, "window flag early")
    // An edge always leaves still mode.
    `RMPC_ASSERT_SAME(a_edge_mode, i_out_valid && (i_edge_seen != rmpc_pkg::EDGE_NONE), i_meter_mode != rmpc_pkg::MODE_STILL, "edge in still mode")

endmodule

bind reflective_meter_pulse_counter_core rmpc_checker #(
    .CAL_PULSES (CAL_PULSES)
) u_rmpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_pulse_count   (o_out.pulse_count),
    .i_edge_seen     (o_out.edge_seen),
    .i_meter_mode    (o_out.meter_mode),
    .i_calibrated    (o_out.calibrated),
    .i_out_of_window (o_out.out_of_window)
);
